/* src/fmi_pkg.sv */
// Shared types and constants for the flow meter with inter-arrival statistics.
`default_nettype none
package fmi_pkg;

    localparam int unsigned KEY_ADDR_W = 64;
    localparam int unsigned KEY_PPP_W  = 40;
    localparam int unsigned MEAN_W     = 48;
    localparam int unsigned DIV_CNT_W  = 7;

    typedef logic [1:0] t_status;
    localparam t_status ST_UPDATED = 2'd0;
    localparam t_status ST_NEW     = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_VRD,
        S_RD,
        S_CMP,
        S_UPD,
        S_PREP,
        S_MDIV,
        S_MUL,
        S_VDIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [KEY_ADDR_W-1:0] key_addr;
        logic [KEY_PPP_W-1:0]  key_ppp;
        logic [63:0]           pkts;
        logic [63:0]           bytes;
        logic [63:0]           first;
        logic [63:0]           last;
        logic [MEAN_W-1:0]     mean;
        logic [63:0]           m2;
    } t_entry;

endpackage
`default_nettype wire

/* src/fmi_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module fmi_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [63:0]                    i_dividend,
    input  wire logic [63:0]                    i_divisor,
    input  wire logic [fmi_pkg::DIV_CNT_W-1:0] i_nbits,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [63:0]                         o_quotient
);
    // dividend is left aligned by the caller; i_nbits bits are processed
    logic [63:0]                         r_q;
    logic [63:0]                         r_rem;
    logic [63:0]                         r_div;
    logic [fmi_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic                                r_busy;
    logic                                r_done;
    logic [65:0]                         trial;

    assign trial = {1'b0, r_rem, r_q[63]} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                // one shift and trial subtract per cycle
                if (!trial[65]) begin
                    r_rem <= trial[63:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_q[63]};
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fmi_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_q;
endmodule
`default_nettype wire

/* src/fmi_mul.sv */
// 48x48 multiplier built from one 24x24 product per cycle; returns floor(a*b / 2^32).
`default_nettype none
module fmi_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_a,
    input  wire logic [47:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_prod
);
    logic [47:0] r_a;
    logic [47:0] r_b;
    logic [2:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [47:0] r_pp;
    logic [5:0]  r_sh;
    logic        r_ppv;
    logic [95:0] r_acc;
    logic [23:0] mx;
    logic [23:0] my;
    logic [5:0]  sh;

    // partial product select: lo*lo, hi*lo, lo*hi, hi*hi
    always_comb begin
        unique case (r_step[1:0])
            2'd0: begin mx = r_a[23:0];  my = r_b[23:0];  sh = 6'd0;  end
            2'd1: begin mx = r_a[47:24]; my = r_b[23:0];  sh = 6'd24; end
            2'd2: begin mx = r_a[23:0];  my = r_b[47:24]; sh = 6'd24; end
            default: begin mx = r_a[47:24]; my = r_b[47:24]; sh = 6'd48; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_busy <= 1'b1;
                r_step <= '0;
                r_ppv  <= 1'b0;
                r_acc  <= '0;
            end else if (r_busy) begin
                // multiply one step, accumulate the previous product
                if (r_ppv) begin
                    r_acc <= r_acc + ({48'd0, r_pp} << r_sh);
                end
                r_pp   <= mx * my;
                r_sh   <= sh;
                r_ppv  <= (r_step != 3'd4);
                r_step <= r_step + 1'b1;
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[95:32];
endmodule
`default_nettype wire

/* src/flow_meter_iat_stats.sv */
// Flow meter top level: flow table, sequencer and Welford gap statistics.
//
// One packet record per transaction. The block takes one record at a time and
// stalls its input until that record's result is loaded into the output
// register. The bucket index is found with a reciprocal multiply on the shared
// multiplier; the mean step and the sample variance share one radix-2 divider.
// A new or dropped flow needs only the bucket search; the second packet of a
// flow sets the mean directly; later packets add a 48-bit divide, a multiply
// and a 64-bit divide. A stalled output holds the sequencer in its output
// state. After reset a clearing pass over all BUCKETS rows zeroes the valid
// bits before the first record is taken.
`default_nettype none
module flow_meter_iat_stats #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_source_address,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [15:0] i_source_port,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [7:0]  i_protocol_number,
    input  wire logic [15:0] i_packet_length,
    input  wire logic [63:0] i_arrival_time,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_flow_packets,
    output logic [63:0]      o_flow_bytes,
    output logic [63:0]      o_first_time,
    output logic [63:0]      o_latest_time,
    output logic [47:0]      o_gap_mean,
    output logic [63:0]      o_gap_variance
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AW = $clog2(BUCKETS * WAYS);
    localparam int ENTRIES = BUCKETS * WAYS;
    // hash / BUCKETS = (hash * HASH_RECIP) >> (32 + HL), exact for 32-bit hashes
    localparam int HL = $clog2(BUCKETS);
    localparam logic [63:0] HASH_RECIP = ((64'd1 << (32 + HL)) + 64'(BUCKETS) - 64'd1)
                                       / 64'(BUCKETS);

    fmi_pkg::t_state r_state;
    fmi_pkg::t_state n_state;

    // latched transaction
    logic [31:0] r_sa, r_da;
    logic [15:0] r_sp, r_dp, r_len;
    logic [7:0]  r_pr;
    logic [63:0] r_ts;

    logic [BW-1:0]       r_bucket;
    logic [BW-1:0]       r_clr;
    logic [WW-1:0]       r_way;
    logic [WW-1:0]       r_free;
    logic                r_have_free;
    logic [AW-1:0]       r_addr;
    fmi_pkg::t_entry     r_ent;
    fmi_pkg::t_entry     r_rd;
    fmi_pkg::t_status    r_stat;
    logic [63:0]         r_var;
    logic [47:0]         r_gq;
    logic [47:0]         r_d1;
    logic                r_ge;
    logic [WAYS-1:0]     r_vrow;

    // memories: valid bits by bucket row, flow records by entry
    logic [WAYS-1:0]     m_valid [BUCKETS];
    fmi_pkg::t_entry     m_data  [ENTRIES];

    // output register
    logic                r_oval;
    fmi_pkg::t_status    r_o_stat;
    logic [63:0]         r_o_pkts, r_o_bytes, r_o_first, r_o_last, r_o_var;
    logic [47:0]         r_o_mean;

    // shared units
    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend, div_divisor, div_q;
    logic [fmi_pkg::DIV_CNT_W-1:0] div_nbits;
    logic        mul_start, mul_done;
    logic [47:0] mul_a, mul_b;
    logic [63:0] mul_prod;

    logic [31:0] hash, lat_hash;
    logic [63:0] hash_quo, hash_rem;
    logic [AW-1:0] rd_addr;
    logic        accept, out_free, hit_now, vwr, dwr, last_way;
    logic [47:0] d1, nm, d2;
    logic [64:0] m2_sum;
    logic [63:0] m2_next, gap;
    logic [64:0] bytes_sum;

    fmi_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .i_nbits     (div_nbits),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_q)
    );

    fmi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // datapath helpers
    assign hash = i_source_address ^ i_dest_address ^ {i_source_port, 16'd0}
                ^ {16'd0, i_dest_port};
    assign lat_hash = r_sa ^ r_da ^ {r_sp, 16'd0} ^ {16'd0, r_dp};
    assign hash_quo = mul_prod >> HL;
    assign hash_rem = {32'd0, lat_hash} - hash_quo * 64'(BUCKETS);
    assign rd_addr  = AW'(AW'(r_bucket) * AW'(WAYS) + AW'(r_way));
    assign accept   = (r_state == fmi_pkg::S_IDLE) && i_in_valid;
    assign out_free = !r_oval || !i_out_stall;
    assign last_way = (r_way == WW'(WAYS - 1));
    assign hit_now  = r_vrow[r_way] && (r_rd.key_addr == {r_sa, r_da})
                   && (r_rd.key_ppp == {r_sp, r_dp, r_pr});
    assign gap      = (r_ts > r_ent.last) ? (r_ts - r_ent.last) : 64'd0;
    assign bytes_sum = {1'b0, r_ent.bytes} + {49'd0, r_len};
    assign d1       = (r_gq >= r_ent.mean) ? (r_gq - r_ent.mean) : (r_ent.mean - r_gq);
    assign nm       = r_ge ? (r_ent.mean + div_q[47:0]) : (r_ent.mean - div_q[47:0]);
    assign d2       = r_ge ? (r_gq - nm) : (nm - r_gq);
    assign m2_sum   = {1'b0, r_ent.m2} + {1'b0, mul_prod};
    assign m2_next  = m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];
    assign dwr      = (r_state == fmi_pkg::S_OUT) && out_free
                   && (r_stat != fmi_pkg::ST_FULL);
    assign vwr      = dwr && (r_stat == fmi_pkg::ST_NEW);

    // next state and unit control
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 64'd1;
        div_nbits    = fmi_pkg::DIV_CNT_W'(64);
        mul_start    = 1'b0;
        mul_a        = r_d1;
        mul_b        = d2;
        unique case (r_state)
            fmi_pkg::S_CLEAR: if (r_clr == BW'(BUCKETS - 1)) n_state = fmi_pkg::S_IDLE;
            fmi_pkg::S_IDLE: begin
                if (accept) begin
                    mul_start = 1'b1;
                    mul_a     = {16'd0, hash};
                    mul_b     = HASH_RECIP[47:0];
                    n_state   = fmi_pkg::S_HASH;
                end
            end
            fmi_pkg::S_HASH: if (mul_done) n_state = fmi_pkg::S_VRD;
            fmi_pkg::S_VRD:  n_state = fmi_pkg::S_RD;
            fmi_pkg::S_RD:   n_state = fmi_pkg::S_CMP;
            fmi_pkg::S_CMP: begin
                if (hit_now) begin
                    n_state = fmi_pkg::S_UPD;
                end else if (last_way) begin
                    n_state = fmi_pkg::S_OUT;
                end else begin
                    n_state = fmi_pkg::S_RD;
                end
            end
            fmi_pkg::S_UPD: n_state = fmi_pkg::S_PREP;
            fmi_pkg::S_PREP: begin
                if (r_ent.pkts == 64'd2) begin
                    n_state = fmi_pkg::S_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {d1, 16'd0};
                    div_divisor  = r_ent.pkts - 64'd1;
                    div_nbits    = fmi_pkg::DIV_CNT_W'(48);
                    n_state      = fmi_pkg::S_MDIV;
                end
            end
            fmi_pkg::S_MDIV: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = fmi_pkg::S_MUL;
                end
            end
            fmi_pkg::S_MUL: begin
                if (mul_done) begin
                    div_start    = 1'b1;
                    div_dividend = m2_next;
                    div_divisor  = r_ent.pkts - 64'd2;
                    div_nbits    = fmi_pkg::DIV_CNT_W'(64);
                    n_state      = fmi_pkg::S_VDIV;
                end
            end
            fmi_pkg::S_VDIV: if (div_done) n_state = fmi_pkg::S_OUT;
            fmi_pkg::S_OUT:  if (out_free) n_state = fmi_pkg::S_IDLE;
            default: n_state = fmi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmi_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            unique case (r_state)
                fmi_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                fmi_pkg::S_IDLE: begin
                    if (accept) begin
                        r_sa  <= i_source_address;
                        r_da  <= i_dest_address;
                        r_sp  <= i_source_port;
                        r_dp  <= i_dest_port;
                        r_pr  <= i_protocol_number;
                        r_len <= i_packet_length;
                        r_ts  <= i_arrival_time;
                    end
                    r_way       <= '0;
                    r_have_free <= 1'b0;
                end
                fmi_pkg::S_HASH: if (mul_done) r_bucket <= hash_rem[BW-1:0];
                fmi_pkg::S_CMP: begin
                    if (hit_now) begin
                        r_ent  <= r_rd;
                        r_addr <= rd_addr;
                        r_stat <= fmi_pkg::ST_UPDATED;
                    end else begin
                        if (!r_vrow[r_way] && !r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free      <= r_way;
                        end
                        if (last_way) begin
                            // new flow in the lowest free way, or bucket full
                            if (r_have_free || !r_vrow[r_way]) begin
                                r_stat <= fmi_pkg::ST_NEW;
                                if (!r_have_free) begin
                                    r_addr <= rd_addr;
                                end else begin
                                    r_addr <= AW'(AW'(r_bucket) * AW'(WAYS) + AW'(r_free));
                                end
                            end else begin
                                r_stat <= fmi_pkg::ST_FULL;
                            end
                            r_ent.key_addr <= {r_sa, r_da};
                            r_ent.key_ppp  <= {r_sp, r_dp, r_pr};
                            r_ent.pkts     <= 64'd1;
                            r_ent.bytes    <= {48'd0, r_len};
                            r_ent.first    <= r_ts;
                            r_ent.last     <= r_ts;
                            r_ent.mean     <= '0;
                            r_ent.m2       <= '0;
                            r_var          <= '0;
                        end else begin
                            r_way <= r_way + 1'b1;
                        end
                    end
                end
                fmi_pkg::S_UPD: begin
                    // gap saturates at 32 bits, counters saturate at 64
                    r_gq <= (gap[63:32] != 32'd0) ? {32'hFFFF_FFFF, 16'd0}
                                                  : {gap[31:0], 16'd0};
                    r_ent.last <= r_ts;
                    if (r_ent.pkts != {64{1'b1}}) r_ent.pkts <= r_ent.pkts + 64'd1;
                    r_ent.bytes <= bytes_sum[64] ? {64{1'b1}} : bytes_sum[63:0];
                end
                fmi_pkg::S_PREP: begin
                    if (r_ent.pkts == 64'd2) begin
                        r_ent.mean <= r_gq;
                        r_ent.m2   <= '0;
                        r_var      <= '0;
                    end else begin
                        r_d1 <= d1;
                    end
                end
                fmi_pkg::S_MDIV: if (div_done) r_ent.mean <= nm;
                fmi_pkg::S_MUL:  if (mul_done) r_ent.m2 <= m2_next;
                fmi_pkg::S_VDIV: if (div_done) r_var <= div_q;
                default: begin
                end
            endcase
            // direction of the mean step is fixed once the gap is known
            if (r_state == fmi_pkg::S_PREP) begin
                r_ge <= (r_gq >= r_ent.mean);
            end
        end
    end

    // valid-bit rows: cleared by the sweep, set when a flow is created
    always_ff @(posedge i_clk) begin
        if (r_state == fmi_pkg::S_CLEAR) begin
            m_valid[r_clr] <= '0;
        end else if (vwr) begin
            m_valid[r_bucket] <= r_vrow | (WAYS'(1) << r_free);
        end
        r_vrow <= m_valid[r_bucket];
    end

    // flow record memory
    always_ff @(posedge i_clk) begin
        if (dwr) begin
            m_data[r_addr] <= r_ent;
        end
        r_rd <= m_data[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else begin
            if ((r_state == fmi_pkg::S_OUT) && out_free) begin
                r_oval   <= 1'b1;
                r_o_stat <= r_stat;
                if (r_stat == fmi_pkg::ST_FULL) begin
                    r_o_pkts  <= '0;
                    r_o_bytes <= '0;
                    r_o_first <= '0;
                    r_o_last  <= '0;
                    r_o_mean  <= '0;
                    r_o_var   <= '0;
                end else begin
                    r_o_pkts  <= r_ent.pkts;
                    r_o_bytes <= r_ent.bytes;
                    r_o_first <= r_ent.first;
                    r_o_last  <= r_ent.last;
                    r_o_mean  <= r_ent.mean;
                    r_o_var   <= r_var;
                end
            end else if (!i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_in_stall     = (r_state != fmi_pkg::S_IDLE);
    assign o_out_valid    = r_oval;
    assign o_status       = r_o_stat;
    assign o_flow_packets = r_o_pkts;
    assign o_flow_bytes   = r_o_bytes;
    assign o_first_time   = r_o_first;
    assign o_latest_time  = r_o_last;
    assign o_gap_mean     = r_o_mean;
    assign o_gap_variance = r_o_var;

    // one record in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a record is in flight");

    // the shared divider is never restarted while running
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // dropped packets carry zero statistics
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == fmi_pkg::ST_FULL)) |-> (o_flow_packets == 64'd0))
        else $error("dropped result with nonzero count");

    // a created or updated flow always has at least one packet
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != fmi_pkg::ST_FULL)) |-> (o_flow_packets != 64'd0))
        else $error("live flow result with zero count");

endmodule
`default_nettype wire
